// ----- src/ddays_pkg.sv -----
package ddays_pkg;

  localparam int unsigned DayW    = 5;
  localparam int unsigned MonthW  = 4;
  localparam int unsigned YearW   = 14;
  localparam int unsigned CountW  = 22;
  localparam int unsigned SerialW = 23;
  localparam int unsigned BeforeW = 9;
  localparam int unsigned QuotW   = 9;
  localparam int unsigned QDepth  = 2;

  localparam logic [MonthW-1:0] MonthJan = 4'd1;
  localparam logic [MonthW-1:0] MonthFeb = 4'd2;
  localparam logic [MonthW-1:0] MonthDec = 4'd12;

  localparam logic [12:0] Recip25      = 13'd5243;
  localparam logic [CountW-1:0] CountMax = {CountW{1'b1}};

  typedef struct packed {
    logic [DayW-1:0]   start_day;
    logic [MonthW-1:0] start_month;
    logic [YearW-1:0]  start_year;
    logic [DayW-1:0]   end_day;
    logic [MonthW-1:0] end_month;
    logic [YearW-1:0]  end_year;
    logic              count_end_day;
  } req_t;

  typedef struct packed {
    logic [CountW-1:0] day_count;
    logic              bad_date;
  } rsp_t;

  typedef struct packed {
    req_t req;
    logic bad;
    logic start_leap;
    logic end_leap;
  } entry_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  // floor(z / 25), exact for z below 43690
  function automatic logic [QuotW-1:0] div25(input logic [12:0] z);
    logic [25:0] prod;
    prod = z * Recip25;
    return prod[25:17];
  endfunction

  function automatic logic is_leap(input logic [YearW-1:0] y);
    logic [26:0]      prod;
    logic [9:0]       q;
    logic [YearW-1:0] r;
    logic             by25;
    prod = y * Recip25;
    q    = prod[26:17];
    r    = y - YearW'({q, 4'd0} + {q, 3'd0} + {4'd0, q});
    by25 = (r == '0);
    return (y[1:0] == 2'd0) && (!by25 || (y[3:0] == 4'd0));
  endfunction

  function automatic logic [DayW-1:0] month_days(input logic [MonthW-1:0] m,
                                                 input logic leap);
    logic [DayW-1:0] d;
    case (m)
      4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: d = 5'd31;
      4'd4, 4'd6, 4'd9, 4'd11:                    d = 5'd30;
      4'd2:                                       d = leap ? 5'd29 : 5'd28;
      default:                                    d = 5'd0;
    endcase
    return d;
  endfunction

  // days in the months before m of a common year
  function automatic logic [BeforeW-1:0] days_before(input logic [MonthW-1:0] m);
    logic [BeforeW-1:0] n;
    case (m)
      4'd2:    n = 9'd31;
      4'd3:    n = 9'd59;
      4'd4:    n = 9'd90;
      4'd5:    n = 9'd120;
      4'd6:    n = 9'd151;
      4'd7:    n = 9'd181;
      4'd8:    n = 9'd212;
      4'd9:    n = 9'd243;
      4'd10:   n = 9'd273;
      4'd11:   n = 9'd304;
      4'd12:   n = 9'd334;
      default: n = 9'd0;
    endcase
    return n;
  endfunction

endpackage

// ----- src/date_difference_in_days.sv -----
// channel   | ports                  | direction | handshake
// ----------+------------------------+-----------+----------------------------
// request   | start_i, busy_o, req_i | in        | taken when start_i && !busy_o
// result    | done_o, rsp_o          | out       | one-cycle strobe, no stall
//
// a request enters a two-entry queue in the cycle it is taken
// a valid pair steps through multiply, add, multiply, add and compare, an invalid one skips them;
// the day numbers of both dates go through one shared multiply-then-add step
// the result is shown in the cycle after the compare step, for one cycle only
// busy_o is high while the queue is full; reset clears queue and counting unit
module date_difference_in_days #(
  parameter int unsigned MAX_YEAR = 9999
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start_i,
  input  ddays_pkg::req_t req_i,
  output logic            busy_o,
  output logic            done_o,
  output ddays_pkg::rsp_t rsp_o
);

  logic               push;
  logic               pop;
  ddays_pkg::entry_t  entry_in;
  ddays_pkg::entry_t  entry_head;
  ddays_pkg::q_stat_t stat;

  ddays_front #(
    .MAX_YEAR(MAX_YEAR)
  ) u_front (
    .start_i (start_i),
    .req_i   (req_i),
    .stat_i  (stat),
    .busy_o  (busy_o),
    .push_o  (push),
    .entry_o (entry_in)
  );

  ddays_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .wdata_i (entry_in),
    .pop_i   (pop),
    .rdata_o (entry_head),
    .stat_o  (stat)
  );

  ddays_back u_back (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .head_i (entry_head),
    .stat_i (stat),
    .pop_o  (pop),
    .done_o (done_o),
    .rsp_o  (rsp_o)
  );

endmodule

// ----- src/ddays_queue.sv -----
module ddays_queue (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  ddays_pkg::entry_t   wdata_i,
  input  logic                pop_i,
  output ddays_pkg::entry_t   rdata_o,
  output ddays_pkg::q_stat_t  stat_o
);

  localparam int unsigned PtrW = $clog2(ddays_pkg::QDepth);
  localparam int unsigned CntW = $clog2(ddays_pkg::QDepth + 1);

  ddays_pkg::entry_t mem_q [ddays_pkg::QDepth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] count_q, count_d;

  assign stat_o.full  = (count_q == CntW'(ddays_pkg::QDepth));
  assign stat_o.empty = (count_q == '0);
  assign rdata_o      = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = wr_ptr_q + PtrW'(1);
    end
    if (pop_i) begin
      rd_ptr_d = rd_ptr_q + PtrW'(1);
    end
    if (push_i && !pop_i) begin
      count_d = count_q + CntW'(1);
    end else if (pop_i && !push_i) begin
      count_d = count_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= wdata_i;
    end
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> !stat_o.full)
    else $error("queue push while full");

  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> !stat_o.empty)
    else $error("queue pop while empty");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(ddays_pkg::QDepth))
    else $error("queue count out of range");

endmodule

// ----- src/ddays_front.sv -----
module ddays_front #(
  parameter int unsigned MAX_YEAR = 9999
) (
  input  logic               start_i,
  input  ddays_pkg::req_t    req_i,
  input  ddays_pkg::q_stat_t stat_i,
  output logic               busy_o,
  output logic               push_o,
  output ddays_pkg::entry_t  entry_o
);

  localparam logic [ddays_pkg::YearW-1:0] MaxYear = ddays_pkg::YearW'(MAX_YEAR);

  logic start_leap, end_leap;
  logic start_ok, end_ok;

  assign start_leap = ddays_pkg::is_leap(req_i.start_year);
  assign end_leap   = ddays_pkg::is_leap(req_i.end_year);

  assign start_ok = (req_i.start_year <= MaxYear)
                 && (req_i.start_day != '0)
                 && (req_i.start_day <= ddays_pkg::month_days(req_i.start_month, start_leap));
  assign end_ok   = (req_i.end_year <= MaxYear)
                 && (req_i.end_day != '0)
                 && (req_i.end_day <= ddays_pkg::month_days(req_i.end_month, end_leap));

  assign busy_o = stat_i.full;
  assign push_o = start_i && !stat_i.full;

  assign entry_o.req        = req_i;
  assign entry_o.bad        = !(start_ok && end_ok);
  assign entry_o.start_leap = start_leap;
  assign entry_o.end_leap   = end_leap;

endmodule

// ----- src/ddays_back.sv -----
module ddays_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  ddays_pkg::entry_t  head_i,
  input  ddays_pkg::q_stat_t stat_i,
  output logic               pop_o,
  output logic               done_o,
  output ddays_pkg::rsp_t    rsp_o
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_MUL  = 3'd1;
  localparam logic [2:0] S_ADD  = 3'd2;
  localparam logic [2:0] S_CMP  = 3'd3;

  localparam int unsigned SW = ddays_pkg::SerialW;

  logic [2:0] state_q, state_d;
  logic       sel_q, sel_d;
  logic       done_q, done_d;

  ddays_pkg::entry_t entry_q, entry_d;
  ddays_pkg::rsp_t   rsp_q, rsp_d;
  logic [ddays_pkg::QuotW-1:0] q100_q, q100_d, q400_q, q400_d;
  logic [SW-1:0] y365_q, y365_d;
  logic [SW-1:0] a_q, a_d, b_q, b_d;

  logic [ddays_pkg::YearW-1:0]  y;
  logic [ddays_pkg::MonthW-1:0] m;
  logic [ddays_pkg::DayW-1:0]   d;
  logic                         leap;
  logic [ddays_pkg::YearW:0]    y99, y399, y3;
  logic [SW-1:0]                serial;
  logic [SW-1:0]                diff;
  logic [SW:0]                  total;

  // current date of the pair
  always_comb begin
    if (sel_q) begin
      y    = entry_q.req.end_year;
      m    = entry_q.req.end_month;
      d    = entry_q.req.end_day;
      leap = entry_q.end_leap;
    end else begin
      y    = entry_q.req.start_year;
      m    = entry_q.req.start_month;
      d    = entry_q.req.start_day;
      leap = entry_q.start_leap;
    end
  end

  assign y99  = {1'b0, y} + 15'd99;
  assign y399 = {1'b0, y} + 15'd399;
  assign y3   = {1'b0, y} + 15'd3;

  // day number from year 0, january 1
  assign serial = y365_q
                + SW'(y3[ddays_pkg::YearW:2])
                - SW'(q100_q)
                + SW'(q400_q)
                + SW'(ddays_pkg::days_before(m))
                + SW'(leap && (m > ddays_pkg::MonthFeb))
                + SW'(d)
                - SW'(1);

  assign diff  = (a_q < b_q) ? (b_q - a_q) : '0;
  assign total = {1'b0, diff} + (SW+1)'(entry_q.req.count_end_day);

  assign pop_o = (state_q == S_IDLE) && !stat_i.empty;

  always_comb begin
    state_d = state_q;
    sel_d   = sel_q;
    done_d  = 1'b0;
    entry_d = entry_q;
    rsp_d   = rsp_q;
    q100_d  = q100_q;
    q400_d  = q400_q;
    y365_d  = y365_q;
    a_d     = a_q;
    b_d     = b_q;
    unique case (state_q)
      S_IDLE: begin
        if (pop_o) begin
          entry_d = head_i;
          if (head_i.bad) begin
            done_d          = 1'b1;
            rsp_d.day_count = '0;
            rsp_d.bad_date  = 1'b1;
          end else begin
            sel_d   = 1'b0;
            state_d = S_MUL;
          end
        end
      end
      S_MUL: begin
        q100_d  = ddays_pkg::div25(y99[ddays_pkg::YearW:2]);
        q400_d  = ddays_pkg::div25({2'b00, y399[ddays_pkg::YearW:4]});
        y365_d  = SW'(y) * SW'(365);
        state_d = S_ADD;
      end
      S_ADD: begin
        if (sel_q) begin
          b_d     = serial;
          state_d = S_CMP;
        end else begin
          a_d     = serial;
          sel_d   = 1'b1;
          state_d = S_MUL;
        end
      end
      S_CMP: begin
        done_d         = 1'b1;
        rsp_d.bad_date = 1'b0;
        if (total > (SW+1)'(ddays_pkg::CountMax)) begin
          rsp_d.day_count = ddays_pkg::CountMax;
        end else begin
          rsp_d.day_count = total[ddays_pkg::CountW-1:0];
        end
        state_d = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      sel_q   <= 1'b0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      sel_q   <= sel_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
    rsp_q   <= rsp_d;
    q100_q  <= q100_d;
    q400_q  <= q400_d;
    y365_q  <= y365_d;
    a_q     <= a_d;
    b_q     <= b_d;
  end

  assign done_o = done_q;
  assign rsp_o  = rsp_q;

  a_bad_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q && rsp_q.bad_date |-> rsp_q.day_count == '0)
    else $error("bad date reported with nonzero count");

  a_good_from_cmp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(done_q) && !rsp_q.bad_date |-> $past(state_q) == S_CMP)
    else $error("count reported without compare step");

  a_busy_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q != S_IDLE |-> !entry_q.bad)
    else $error("bad request entered the count sequence");

endmodule

// ----- dv/testbench.sv -----
`timescale 1ns / 1ps

module testbench;
  import ddays_pkg::*;

  localparam int unsigned MaxYear        = 9999;
  localparam int unsigned CycleLimit     = 400000;
  localparam int unsigned DrainCycles    = 24;
  localparam int unsigned RandomPerPhase = 483;
  localparam int unsigned PrintLimit     = 100;

  typedef struct packed {
    req_t req;
    logic typed;
    rsp_t rsp;
  } dir_row_t;

  typedef struct packed {
    req_t req;
    rsp_t rsp;
  } span_t;

  logic clk_i;
  logic rst_ni;
  logic start_i;
  logic busy_o;
  logic done_o;
  req_t req_i;
  rsp_t rsp_o;

  span_t       pending_spans[$];
  dir_row_t    directed_rows[$];
  span_t       oldest;
  int unsigned errors = 0;
  int unsigned cycles = 0;
  int unsigned sender_idle;

  int unsigned edge_years[12] = '{0, 1, 3, 4, 99, 100, 399, 400, 1900, 2000, 9996, 9999};
  int unsigned idle_by_phase[4] = '{0, 51, 0, 38};

  date_difference_in_days #(
    .MAX_YEAR(MaxYear)
  ) dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(start_i),
    .req_i  (req_i),
    .busy_o (busy_o),
    .done_o (done_o),
    .rsp_o  (rsp_o)
  );

  initial clk_i = 1'b0;
  always #4 clk_i = ~clk_i;

  function automatic logic leap_year(input int unsigned y);
    return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
  endfunction

  function automatic int unsigned month_length(input int unsigned m, input int unsigned y);
    if (m < MonthJan || m > MonthDec) begin
      return 0;
    end
    if (m == MonthFeb) begin
      return leap_year(y) ? 29 : 28;
    end
    if (m == 4 || m == 6 || m == 9 || m == 11) begin
      return 30;
    end
    return 31;
  endfunction

  function automatic logic date_ok(input int unsigned d, input int unsigned m,
                                   input int unsigned y);
    return (y <= MaxYear) && (m >= MonthJan) && (m <= MonthDec) && (d >= 1) &&
           (d <= month_length(m, y));
  endfunction

  function automatic int unsigned day_number(input int unsigned d, input int unsigned m,
                                             input int unsigned y);
    int unsigned n;
    n = 365 * y + (y + 3) / 4 - (y + 99) / 100 + (y + 399) / 400;
    for (int unsigned k = MonthJan; k < m; k++) begin
      n += month_length(k, y);
    end
    return n + d - 1;
  endfunction

  function automatic rsp_t day_span(input req_t r);
    rsp_t        s;
    int unsigned a;
    int unsigned b;
    int unsigned n;
    s = '0;
    if (!date_ok(r.start_day, r.start_month, r.start_year) ||
        !date_ok(r.end_day, r.end_month, r.end_year)) begin
      s.bad_date = 1'b1;
      return s;
    end
    a = day_number(r.start_day, r.start_month, r.start_year);
    b = day_number(r.end_day, r.end_month, r.end_year);
    n = (a < b) ? (b - a) : 0;
    n += r.count_end_day;
    if (n > CountMax) begin
      n = CountMax;
    end
    s.day_count = CountW'(n);
    return s;
  endfunction

  function automatic dir_row_t dir_row(input int unsigned sd, input int unsigned sm,
                                       input int unsigned sy, input int unsigned ed,
                                       input int unsigned em, input int unsigned ey,
                                       input logic inc, input logic typed,
                                       input int unsigned cnt, input logic bad);
    dir_row_t row;
    row.req.start_day     = DayW'(sd);
    row.req.start_month   = MonthW'(sm);
    row.req.start_year    = YearW'(sy);
    row.req.end_day       = DayW'(ed);
    row.req.end_month     = MonthW'(em);
    row.req.end_year      = YearW'(ey);
    row.req.count_end_day = inc;
    row.typed             = typed;
    row.rsp.day_count     = CountW'(cnt);
    row.rsp.bad_date      = bad;
    return row;
  endfunction

  function automatic int unsigned random_year();
    if ($urandom_range(99) < 15) begin
      return edge_years[$urandom_range(11)];
    end
    return $urandom_range(MaxYear);
  endfunction

  function automatic void random_date(output logic [DayW-1:0] d, output logic [MonthW-1:0] m,
                                      inout logic [YearW-1:0] y);
    int unsigned len;
    m   = MonthW'($urandom_range(MonthDec, MonthJan));
    len = month_length(m, y);
    d   = ($urandom_range(99) < 20) ? DayW'(len) : DayW'($urandom_range(len, 1));
  endfunction

  function automatic void break_date(inout logic [DayW-1:0] d, inout logic [MonthW-1:0] m,
                                     inout logic [YearW-1:0] y);
    int unsigned len;
    case ($urandom_range(3))
      0: begin
        len = month_length(m, y);
        d   = (len < 31 && $urandom_range(1)) ? DayW'($urandom_range(31, len + 1)) : '0;
      end
      1: begin
        m = $urandom_range(1) ? '0 : MonthW'($urandom_range(15, 13));
      end
      2: begin
        y = YearW'($urandom_range(16383, MaxYear + 1));
      end
      default: begin
        y = YearW'($urandom_range(MaxYear) | 1);
        m = MonthFeb;
        d = DayW'(29);
      end
    endcase
  endfunction

  function automatic req_t random_request();
    req_t        r;
    int unsigned sel;
    int unsigned ey;
    sel = $urandom_range(99);
    if (sel < 8) begin
      r.start_day   = DayW'($urandom);
      r.start_month = MonthW'($urandom);
      r.start_year  = YearW'($urandom);
      r.end_day     = DayW'($urandom);
      r.end_month   = MonthW'($urandom);
      r.end_year    = YearW'($urandom);
    end else begin
      r.start_year = YearW'(random_year());
      random_date(r.start_day, r.start_month, r.start_year);
      if ($urandom_range(99) < 40) begin
        ey         = r.start_year + $urandom_range(3);
        r.end_year = YearW'((ey > MaxYear) ? MaxYear : ey);
      end else begin
        r.end_year = YearW'(random_year());
      end
      random_date(r.end_day, r.end_month, r.end_year);
      if (sel < 20) begin
        if ($urandom_range(1)) begin
          break_date(r.start_day, r.start_month, r.start_year);
        end else begin
          break_date(r.end_day, r.end_month, r.end_year);
        end
      end
    end
    r.count_end_day = 1'($urandom_range(1));
    return r;
  endfunction

  task automatic report_mismatch(input string what);
    errors++;
    if (errors <= PrintLimit) begin
      $display("mismatch at cycle %0d: %s", cycles, what);
    end
  endtask

  task automatic send_request(input req_t r, input rsp_t want);
    span_t s;
    while (sender_idle != 0 && $urandom_range(99) < sender_idle) begin
      start_i <= 1'b0;
      req_i   <= random_request();
      @(posedge clk_i);
    end
    start_i <= 1'b1;
    req_i   <= r;
    do begin
      @(posedge clk_i);
    end while (busy_o);
    s.req = r;
    s.rsp = want;
    pending_spans.push_back(s);
  endtask

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("testbench: done, errors");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && done_o) begin
      if (pending_spans.size() == 0) begin
        report_mismatch($sformatf("result with no request pending: count %0d bad %0b",
                                  rsp_o.day_count, rsp_o.bad_date));
      end else begin
        oldest = pending_spans.pop_front();
        if (rsp_o.day_count !== oldest.rsp.day_count) begin
          report_mismatch($sformatf("day_count %0d, want %0d for %0d-%0d-%0d .. %0d-%0d-%0d",
                                    rsp_o.day_count, oldest.rsp.day_count,
                                    oldest.req.start_year, oldest.req.start_month,
                                    oldest.req.start_day, oldest.req.end_year,
                                    oldest.req.end_month, oldest.req.end_day));
        end
        if (rsp_o.bad_date !== oldest.rsp.bad_date) begin
          report_mismatch($sformatf("bad_date %0b, want %0b for %0d-%0d-%0d .. %0d-%0d-%0d",
                                    rsp_o.bad_date, oldest.rsp.bad_date,
                                    oldest.req.start_year, oldest.req.start_month,
                                    oldest.req.start_day, oldest.req.end_year,
                                    oldest.req.end_month, oldest.req.end_day));
        end
      end
    end
  end

  initial begin
    req_t r;
    rst_ni      = 1'b0;
    start_i     = 1'b0;
    req_i       = '0;
    sender_idle = 0;

    // identical dates, full span, reversed span
    directed_rows.push_back(dir_row(1, 1, 0, 1, 1, 0, 0, 1, 0, 0));
    directed_rows.push_back(dir_row(1, 1, 0, 1, 1, 0, 1, 1, 1, 0));
    directed_rows.push_back(dir_row(1, 1, 0, 31, 12, 9999, 0, 1, 3652424, 0));
    directed_rows.push_back(dir_row(1, 1, 0, 31, 12, 9999, 1, 1, 3652425, 0));
    directed_rows.push_back(dir_row(31, 12, 9999, 1, 1, 0, 0, 1, 0, 0));
    directed_rows.push_back(dir_row(31, 12, 9999, 1, 1, 0, 1, 1, 1, 0));
    // invalid dates
    directed_rows.push_back(dir_row(1, 0, 2000, 1, 1, 2001, 1, 1, 0, 1));
    directed_rows.push_back(dir_row(1, 1, 2000, 1, 15, 2001, 1, 1, 0, 1));
    directed_rows.push_back(dir_row(0, 3, 2000, 1, 4, 2000, 0, 1, 0, 1));
    directed_rows.push_back(dir_row(1, 3, 2000, 31, 4, 2000, 1, 1, 0, 1));
    directed_rows.push_back(dir_row(29, 2, 1900, 1, 3, 1900, 0, 1, 0, 1));
    directed_rows.push_back(dir_row(30, 2, 2000, 1, 3, 2000, 1, 1, 0, 1));
    directed_rows.push_back(dir_row(1, 1, 10000, 1, 1, 9999, 0, 1, 0, 1));
    directed_rows.push_back(dir_row(31, 15, 16383, 31, 15, 16383, 1, 1, 0, 1));
    directed_rows.push_back(dir_row(5, 6, 2010, 0, 6, 2011, 1, 1, 0, 1));
    // leap year boundaries
    directed_rows.push_back(dir_row(29, 2, 2000, 1, 3, 2000, 0, 0, 0, 0));
    directed_rows.push_back(dir_row(28, 2, 1900, 1, 3, 1900, 0, 0, 0, 0));
    directed_rows.push_back(dir_row(28, 2, 2000, 1, 3, 2000, 1, 0, 0, 0));
    directed_rows.push_back(dir_row(29, 2, 0, 1, 3, 0, 0, 0, 0, 0));
    directed_rows.push_back(dir_row(29, 2, 2004, 28, 2, 2005, 0, 0, 0, 0));
    directed_rows.push_back(dir_row(31, 12, 2000, 1, 1, 2001, 0, 0, 0, 0));
    directed_rows.push_back(dir_row(31, 1, 1999, 28, 2, 1999, 1, 0, 0, 0));
    directed_rows.push_back(dir_row(1, 1, 9999, 31, 12, 9999, 0, 0, 0, 0));
    directed_rows.push_back(dir_row(30, 12, 9999, 31, 12, 9999, 1, 0, 0, 0));

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed_rows[i]) begin
      send_request(directed_rows[i].req,
                   directed_rows[i].typed ? directed_rows[i].rsp : day_span(directed_rows[i].req));
    end

    foreach (idle_by_phase[p]) begin
      sender_idle = idle_by_phase[p];
      repeat (RandomPerPhase) begin
        r = random_request();
        send_request(r, day_span(r));
      end
    end
    start_i <= 1'b0;

    while (pending_spans.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (DrainCycles) @(posedge clk_i);

    if (errors == 0) begin
      $display("testbench: done, clean");
    end else begin
      $display("testbench: done, errors");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
src/ddays_pkg.sv
src/ddays_queue.sv
src/ddays_front.sv
src/ddays_back.sv
src/date_difference_in_days.sv
dv/testbench.sv
